>>> src/calendar_month_navigator_unit_macros.svh
// ----------------------------------------------------------------------------
// Calendar month navigator assertion macros
// Shorthand for clocked assertions with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_MONTH_NAVIGATOR_UNIT_MACROS_SVH
`define CALENDAR_MONTH_NAVIGATOR_UNIT_MACROS_SVH

// property holds at every clock edge outside reset
`define CMN_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent this cycle implies consequent next cycle
`define CMN_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/cmn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar month navigator package
// Field widths, op codes, calendar tables and reciprocal constants.
// ----------------------------------------------------------------------------
package cmn_pkg;

  localparam int OpW    = 2;
  localparam int DeltaW = 13;
  localparam int YearW  = 14;
  localparam int MonthW = 4;
  localparam int DaysW  = 5;
  localparam int WdayW  = 3;

  // input register, page register, divide stage, sum stage, output register
  localparam int NumStages = 5;

  localparam logic [YearW-1:0] YearMax = 14'd9999;

  // floor(x / 12) = (x * Recip12) >> Recip12Sh for 0 <= x < 12288
  localparam logic [13:0] Recip12   = 14'd10923;
  localparam int          Recip12Sh = 17;
  // month index is biased by 12 * MonthQBias to stay non-negative
  localparam logic signed [15:0] MonthQBias = 16'sd342;
  localparam logic signed [15:0] MonthBias  = 16'sd4104;

  // floor(x / 25) for x < 2500 and for x < 10000
  localparam logic [11:0] Recip25Lo   = 12'd2622;
  localparam int          Recip25LoSh = 16;
  localparam logic [13:0] Recip25Hi   = 14'd10486;
  localparam int          Recip25HiSh = 18;

  // floor(x / 7) for x < 16384
  localparam logic [14:0] Recip7   = 15'd18725;
  localparam int          Recip7Sh = 17;

  typedef enum logic [OpW-1:0] {
    OpShow      = 2'd0,
    OpStepYear  = 2'd1,
    OpStepMonth = 2'd2,
    OpJump      = 2'd3
  } op_e;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
  } page_t;

  typedef struct packed {
    logic [NumStages-1:0] load;
    logic                 commit;
  } pipe_ctl_t;

  function automatic logic month_ok(logic [MonthW-1:0] m);
    return (m >= 4'd1) && (m <= 4'd12);
  endfunction

  function automatic logic [DaysW-1:0] month_len(logic [MonthW-1:0] m);
    logic [DaysW-1:0] d;
    case (m)
      4'd2:                      d = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7,
      4'd8, 4'd10, 4'd12:        d = 5'd31;
      default:                   d = 5'd30;
    endcase
    return d;
  endfunction

  function automatic logic [WdayW-1:0] month_offset(logic [MonthW-1:0] m);
    logic [WdayW-1:0] o;
    case (m)
      4'd1:    o = 3'd0;
      4'd2:    o = 3'd3;
      4'd3:    o = 3'd2;
      4'd4:    o = 3'd5;
      4'd5:    o = 3'd0;
      4'd6:    o = 3'd3;
      4'd7:    o = 3'd5;
      4'd8:    o = 3'd1;
      4'd9:    o = 3'd4;
      4'd10:   o = 3'd6;
      4'd11:   o = 3'd2;
      4'd12:   o = 3'd4;
      default: o = 3'd0;
    endcase
    return o;
  endfunction

endpackage

>>> src/cmn_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar month navigator page step
// Input register, stored page and page update for one beat.
// ----------------------------------------------------------------------------
module cmn_step
  import cmn_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pipe_ctl_t                ctl_i,
  input  logic [OpW-1:0]           op_i,
  input  logic signed [DeltaW-1:0] delta_i,
  input  logic [YearW-1:0]         now_year_i,
  input  logic [MonthW-1:0]        now_month_i,
  output page_t                    page_o
);

  logic [OpW-1:0]           op_q;
  logic signed [DeltaW-1:0] delta_q;
  logic [YearW-1:0]         now_year_q;
  logic [MonthW-1:0]        now_month_q;
  page_t                    state_q;
  page_t                    page_q;

  op_e                op;
  page_t              now_page;
  page_t              base;
  page_t              page_d;
  logic signed [15:0] delta_x;
  logic signed [15:0] year_step;
  logic signed [15:0] m0;
  logic signed [15:0] m_biased;
  logic [13:0]        t;
  logic [27:0]        prod;
  logic [10:0]        qq;
  logic [13:0]        qq12;
  logic [MonthW-1:0]  r;
  logic signed [15:0] year_wrap;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[0]) begin
      op_q        <= op_i;
      delta_q     <= delta_i;
      now_year_q  <= now_year_i;
      now_month_q <= now_month_i;
    end
    if (ctl_i.load[1]) begin
      page_q <= page_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (ctl_i.commit) begin
      state_q <= page_d;
    end
  end

  assign op = op_e'(op_q);

  always_comb begin
    if (now_year_q == '0) begin
      now_page.year = 14'd1;
    end else if (now_year_q > YearMax) begin
      now_page.year = YearMax;
    end else begin
      now_page.year = now_year_q;
    end
    now_page.month = month_ok(now_month_q) ? now_month_q : 4'd1;
  end

  assign base = ((op == OpJump) || (state_q.year == '0) || !month_ok(state_q.month))
              ? now_page : state_q;

  assign delta_x   = $signed({{(16-DeltaW){delta_q[DeltaW-1]}}, delta_q});
  assign year_step = $signed({2'b00, base.year}) + delta_x;

  // floor division by 12 on a biased, non-negative month index
  assign m0        = $signed({12'd0, base.month}) - 16'sd1 + delta_x;
  assign m_biased  = m0 + MonthBias;
  assign t         = m_biased[13:0];
  assign prod      = 28'(t) * 28'(Recip12);
  assign qq        = prod[27:Recip12Sh];
  assign qq12      = 14'({3'b000, qq} << 3) + 14'({3'b000, qq} << 2);
  assign r         = 4'(t - qq12);
  assign year_wrap = $signed({2'b00, base.year}) + $signed({5'b00000, qq}) - MonthQBias;

  always_comb begin
    page_d = base;
    case (op)
      OpShow: begin
        page_d = base;
      end
      OpStepYear: begin
        if (year_step < 16'sd1) begin
          page_d.year = 14'd1;
        end else if (year_step > $signed({2'b00, YearMax})) begin
          page_d.year = YearMax;
        end else begin
          page_d.year = year_step[YearW-1:0];
        end
      end
      OpStepMonth: begin
        if (year_wrap < 16'sd1) begin
          page_d.year  = '0;
          page_d.month = r + 4'd1;
        end else if (year_wrap > $signed({2'b00, YearMax})) begin
          page_d.year  = YearMax;
          page_d.month = 4'd12;
        end else begin
          page_d.year  = year_wrap[YearW-1:0];
          page_d.month = r + 4'd1;
        end
      end
      OpJump: begin
        page_d = now_page;
      end
      default: begin
        page_d = base;
      end
    endcase
  end

  assign page_o = page_q;

endmodule

>>> src/cmn_cal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar month navigator calendar stages
// Days in month and weekday of day one, over three register stages.
// ----------------------------------------------------------------------------
module cmn_cal
  import cmn_pkg::*;
(
  input  logic               clk_i,
  input  pipe_ctl_t          ctl_i,
  input  page_t              page_i,
  output logic [YearW-1:0]   page_year_o,
  output logic [MonthW-1:0]  page_month_o,
  output logic [DaysW-1:0]   month_days_o,
  output logic [WdayW-1:0]   first_weekday_o,
  output logic               page_valid_o
);

  // divide stage
  page_t             p2_q;
  logic [YearW-1:0]  yw2_q;
  logic [7:0]        cq2_q;
  logic [9:0]        q25_2_q;

  logic [YearW-1:0]  yw_d;
  logic [23:0]       cprod;
  logic [27:0]       q25prod;

  // sum stage
  page_t             p3_q;
  logic [DaysW-1:0]  days3_q;
  logic [YearW-1:0]  sum3_q;
  logic              valid3_q;

  logic [YearW-1:0]  mult25;
  logic              leap;
  logic [DaysW-1:0]  days_d;
  logic [YearW-1:0]  sum_d;

  // output stage
  logic [YearW-1:0]  year4_q;
  logic [MonthW-1:0] month4_q;
  logic [DaysW-1:0]  days4_q;
  logic [WdayW-1:0]  wd4_q;
  logic              valid4_q;

  logic [28:0]       sprod;
  logic [11:0]       q7;
  logic [14:0]       q7x7;
  logic [14:0]       rem7;

  // weekday year: Jan and Feb count with the previous year
  assign yw_d    = (page_i.month < 4'd3) ? page_i.year - 14'd1 : page_i.year;
  assign cprod   = 24'(yw_d[YearW-1:2]) * 24'(Recip25Lo);
  assign q25prod = 28'(page_i.year) * 28'(Recip25Hi);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[2]) begin
      p2_q    <= page_i;
      yw2_q   <= yw_d;
      cq2_q   <= cprod[Recip25LoSh+7:Recip25LoSh];
      q25_2_q <= q25prod[Recip25HiSh+9:Recip25HiSh];
    end
  end

  assign mult25 = 14'({4'b0000, q25_2_q} << 4) + 14'({4'b0000, q25_2_q} << 3)
                + 14'(q25_2_q);
  assign leap   = (p2_q.year[1:0] == 2'b00)
               && ((p2_q.year != mult25) || (p2_q.year[3:0] == 4'b0000));
  assign days_d = ((p2_q.month == 4'd2) && leap) ? 5'd29 : month_len(p2_q.month);
  assign sum_d  = yw2_q + (yw2_q >> 2) - 14'(cq2_q) + 14'(cq2_q >> 2)
                + 14'(month_offset(p2_q.month)) + 14'd1;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[3]) begin
      p3_q     <= p2_q;
      days3_q  <= days_d;
      sum3_q   <= sum_d;
      valid3_q <= (p2_q.year != '0);
    end
  end

  assign sprod = 29'(sum3_q) * 29'(Recip7);
  assign q7    = sprod[Recip7Sh+11:Recip7Sh];
  assign q7x7  = 15'({3'b000, q7} << 3) - 15'(q7);
  assign rem7  = 15'(sum3_q) - q7x7;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load[4]) begin
      year4_q  <= p3_q.year;
      month4_q <= p3_q.month;
      days4_q  <= days3_q;
      wd4_q    <= valid3_q ? rem7[WdayW-1:0] : '0;
      valid4_q <= valid3_q;
    end
  end

  assign page_year_o     = year4_q;
  assign page_month_o    = month4_q;
  assign month_days_o    = days4_q;
  assign first_weekday_o = wd4_q;
  assign page_valid_o    = valid4_q;

endmodule

>>> src/calendar_month_navigator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar month navigator
// Steps a displayed year/month page and reports days in month and the
// weekday of day one.
// ----------------------------------------------------------------------------
// Takes one beat per clock while no stall holds the pipeline, and gives one
// result beat per input beat after the input register, page register, two
// calendar stages and output register. The stored page is updated as a beat
// leaves the input register, so the next beat sees it with no gap.
// Each stage holds its beat only while the stage after it is full and
// stalled; empty stages fill, so a stalled output still lets up to four
// further beats in.
// ----------------------------------------------------------------------------
module calendar_month_navigator_unit
  import cmn_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [OpW-1:0]           op_i,
  input  logic signed [DeltaW-1:0] delta_i,
  input  logic [YearW-1:0]         now_year_i,
  input  logic [MonthW-1:0]        now_month_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [YearW-1:0]         page_year_o,
  output logic [MonthW-1:0]        page_month_o,
  output logic [DaysW-1:0]         month_days_o,
  output logic [WdayW-1:0]         first_weekday_o,
  output logic                     page_valid_o
);

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] valid_d;
  pipe_ctl_t            ctl;
  page_t                page;

  always_comb begin
    ctl.load[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      ctl.load[k] = !valid_q[k] || ctl.load[k+1];
    end
    ctl.commit = ctl.load[1] && valid_q[0];
  end

  always_comb begin
    valid_d = valid_q;
    if (ctl.load[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (ctl.load[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !ctl.load[0];
  assign out_valid_o = valid_q[NumStages-1];

  cmn_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .op_i        (op_i),
    .delta_i     (delta_i),
    .now_year_i  (now_year_i),
    .now_month_i (now_month_i),
    .page_o      (page)
  );

  cmn_cal u_cal (
    .clk_i           (clk_i),
    .ctl_i           (ctl),
    .page_i          (page),
    .page_year_o     (page_year_o),
    .page_month_o    (page_month_o),
    .month_days_o    (month_days_o),
    .first_weekday_o (first_weekday_o),
    .page_valid_o    (page_valid_o)
  );

endmodule

>>> src/cmn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar month navigator checker
// Port-level checks on result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "calendar_month_navigator_unit_macros.svh"

module cmn_checker
  import cmn_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic [OpW-1:0]           op_i,
  input logic signed [DeltaW-1:0] delta_i,
  input logic [YearW-1:0]         now_year_i,
  input logic [MonthW-1:0]        now_month_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [YearW-1:0]         page_year_o,
  input logic [MonthW-1:0]        page_month_o,
  input logic [DaysW-1:0]         month_days_o,
  input logic [WdayW-1:0]         first_weekday_o,
  input logic                     page_valid_o
);

  `CMN_ASSERT(a_valid_flag, clk_i, rst_ni, out_valid_o |-> (page_valid_o == (page_year_o != '0)), "page_valid disagrees with page_year")
  `CMN_ASSERT(a_page_range, clk_i, rst_ni, out_valid_o |-> (page_month_o >= 4'd1 && page_month_o <= 4'd12 && page_year_o <= YearMax), "page out of range")
  `CMN_ASSERT(a_days_wday, clk_i, rst_ni, out_valid_o |-> (month_days_o >= 5'd28 && month_days_o <= 5'd31 && first_weekday_o <= 3'd6), "days or weekday out of range")
  `CMN_ASSERT(a_invalid_wday, clk_i, rst_ni, (out_valid_o && !page_valid_o) |-> (first_weekday_o == '0), "weekday not zero on invalid page")
  `CMN_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(page_year_o) && $stable(first_weekday_o), "stalled result beat changed")

endmodule

bind calendar_month_navigator_unit cmn_checker u_cmn_checker (.*);
